### src/hsad_pkg.sv
// Shared constants, types and the Hall code table for the Hall sector angle decoder.
package hsad_pkg;

  localparam int unsigned HALL_W     = 3;
  localparam int unsigned SECTOR_W   = 3;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned ANGLE_W    = 24;
  localparam int unsigned FRAC_BITS  = 24;
  localparam int unsigned DIV_STEPS  = COUNT_W + FRAC_BITS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FWD_OFFSET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REV_OFFSET = CFG_IDX_W'(1);

  localparam logic [ANGLE_W-1:0]  FWD_OFFSET_RST  = ANGLE_W'(9786708);
  localparam logic [ANGLE_W-1:0]  REV_OFFSET_RST  = ANGLE_W'(1398100);
  localparam logic [SECTOR_W-1:0] SECTOR_RST      = SECTOR_W'(4);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } ctrl_state_e;

  // Per-beat sector decode result.
  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic                changed;
    logic                forward;
  } sector_info_t;

  function automatic logic [SECTOR_W-1:0] hall_to_sector(input logic [HALL_W-1:0] code);
    logic [SECTOR_W-1:0] s;
    unique case (code)
      3'd0:    s = 3'd6;
      3'd1:    s = 3'd3;
      3'd2:    s = 3'd1;
      3'd3:    s = 3'd2;
      3'd4:    s = 3'd5;
      3'd5:    s = 3'd4;
      3'd6:    s = 3'd6;
      default: s = 3'd3;
    endcase
    return s;
  endfunction

endpackage

### src/hall_sector_angle_decoder_core.sv
// Hall sector angle decoder: one Hall sample in, one sector/direction/angle beat out.
// Each input beat maps the three Hall lines through a fixed table to sector 1..6,
// flags a sector change and updates the rotation direction (+1/-5 forward, -1/+5
// reverse, any other step keeps it). When capture_event is set with a nonzero
// period, the angle is re-anchored to offset +/- floor(timer_count*2^24/period)
// modulo 2^24; a zero period raises zero_period_error and keeps the angle.
// Flow: a beat without a usable capture goes straight to DONE, which loads the result
// register once it is free; a beat with a capture first runs the bit-serial divider
// that retires one quotient bit per cycle over 32 count bits plus 24 fraction bits,
// then DIV picks up its registered done flag and DONE loads the result register.
// A new beat is accepted as soon as the previous result sits in the output
// register, even if downstream has not taken it yet. Offset registers
// (index 0 forward, 1 reverse) are written through the cfg port, always ready;
// other indexes are ignored. Writes belong between items.
module hall_sector_angle_decoder_core import hsad_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ANGLE_W-1:0]   cfg_data_i,
  // input beats
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [HALL_W-1:0]    hall_code_i,
  input  logic                 capture_event_i,
  input  logic [COUNT_W-1:0]   timer_count_i,
  input  logic [COUNT_W-1:0]   captured_period_i,
  // result beats
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SECTOR_W-1:0]  sector_o,
  output logic                 sector_changed_o,
  output logic                 direction_o,
  output logic [ANGLE_W-1:0]   electrical_angle_o,
  output logic                 zero_period_error_o
);

  ctrl_state_e state_q, state_d;

  logic               in_fire;
  logic               div_start;
  logic               div_done;
  logic [ANGLE_W-1:0] div_quot;
  sector_info_t       info;

  // per-item context held while the divider runs
  sector_info_t       item_q;
  logic               item_div_q;
  logic               item_zerr_q;

  logic [ANGLE_W-1:0] fwd_off_q, rev_off_q;
  logic [ANGLE_W-1:0] angle_q, angle_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic                out_load;
  logic [SECTOR_W-1:0] out_sector_q;
  logic                out_changed_q, out_dir_q, out_zerr_q;
  logic [ANGLE_W-1:0]  out_angle_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign div_start   = in_fire && capture_event_i && (captured_period_i != '0);

  hsad_sector_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .update_i    (in_fire),
    .hall_code_i (hall_code_i),
    .info_o      (info)
  );

  hsad_serial_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .count_i  (timer_count_i),
    .period_i (captured_period_i),
    .done_o   (div_done),
    .quot_o   (div_quot)
  );

  // control FSM
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = div_start ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // angle re-anchor from the quotient; wraps mod 2^24
  always_comb begin
    angle_d = angle_q;
    if (item_div_q) begin
      angle_d = item_q.forward ? (fwd_off_q + div_quot) : (rev_off_q - div_quot);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      angle_q     <= '0;
      fwd_off_q   <= FWD_OFFSET_RST;
      rev_off_q   <= REV_OFFSET_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (out_load) begin
        angle_q <= angle_d;
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_FWD_OFFSET) begin
          fwd_off_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_REV_OFFSET) begin
          rev_off_q <= cfg_data_i;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q      <= info;
      item_div_q  <= div_start;
      item_zerr_q <= capture_event_i && (captured_period_i == '0);
    end
    if (out_load) begin
      out_sector_q  <= item_q.sector;
      out_changed_q <= item_q.changed;
      out_dir_q     <= item_q.forward;
      out_zerr_q    <= item_zerr_q;
      out_angle_q   <= angle_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign sector_o            = out_sector_q;
  assign sector_changed_o    = out_changed_q;
  assign direction_o         = out_dir_q;
  assign electrical_angle_o  = out_angle_q;
  assign zero_period_error_o = out_zerr_q;

endmodule

### src/hsad_serial_div.sv
// Bit-serial restoring divider: low ANGLE_W bits of (count << FRAC_BITS) / period.
module hsad_serial_div import hsad_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [COUNT_W-1:0] count_i,
  input  logic [COUNT_W-1:0] period_i,
  output logic               done_o,
  output logic [ANGLE_W-1:0] quot_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [COUNT_W-1:0]   num_q, num_d;   // dividend bits, MSB first, zeros after count
  logic [COUNT_W-1:0]   den_q, den_d;
  logic [COUNT_W-1:0]   rem_q, rem_d;
  logic [ANGLE_W-1:0]   quot_q, quot_d;

  logic [COUNT_W:0]     trial;
  logic [COUNT_W:0]     diff;
  logic                 fits;

  always_comb begin
    trial = {rem_q, num_q[COUNT_W-1]};
    diff  = trial - {1'b0, den_q};
    fits  = (trial >= {1'b0, den_q});

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quot_d = quot_q;

    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = count_i;
      den_d  = period_i;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d  = {num_q[COUNT_W-2:0], 1'b0};
      rem_d  = fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
      quot_d = {quot_q[ANGLE_W-2:0], fits};
      cnt_d  = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### src/hsad_sector_track.sv
// Hall code to sector decode with last-sector and rotation direction tracking.
module hsad_sector_track import hsad_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              update_i,
  input  logic [HALL_W-1:0] hall_code_i,
  output sector_info_t      info_o
);

  logic [SECTOR_W-1:0] last_q, last_d;
  logic                fwd_q, fwd_d;
  logic [SECTOR_W-1:0] sector;
  logic [3:0]          delta;  // signed step, -7..7

  always_comb begin
    sector = hall_to_sector(hall_code_i);
    delta  = {1'b0, sector} - {1'b0, last_q};
    last_d = last_q;
    fwd_d  = fwd_q;
    if (sector != last_q) begin
      last_d = sector;
      if (delta == 4'd1 || delta == 4'hB) begin        // +1 or -5 across the wrap
        fwd_d = 1'b1;
      end else if (delta == 4'hF || delta == 4'd5) begin // -1 or +5
        fwd_d = 1'b0;
      end
    end
    info_o.sector  = sector;
    info_o.changed = (sector != last_q);
    info_o.forward = fwd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= SECTOR_RST;
      fwd_q  <= 1'b1;
    end else if (update_i) begin
      last_q <= last_d;
      fwd_q  <= fwd_d;
    end
  end

endmodule

### src/hsad_checker.sv
// Port-level checker for the Hall sector angle decoder, bound to the top level.
module hsad_checker import hsad_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [SECTOR_W-1:0] sector_o,
  input logic                sector_changed_o,
  input logic                direction_o,
  input logic [ANGLE_W-1:0]  electrical_angle_o,
  input logic                zero_period_error_o
);

  logic prev_dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_dir_q <= 1'b1;
    end else if (out_valid_o && out_ready_i) begin
      prev_dir_q <= direction_o;
    end
  end

  // one item in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while previous item still in work");

  // decoded sector always lies in 1..6
  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sector_o != 3'd0 && sector_o != 3'd7))
    else $error("sector out of range");

  // direction only moves on a sector change
  a_dir_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sector_changed_o |-> direction_o == prev_dir_q)
    else $error("direction changed without a sector change");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sector_o)
      && $stable(sector_changed_o) && $stable(direction_o)
      && $stable(electrical_angle_o) && $stable(zero_period_error_o))
    else $error("result beat changed while stalled");

endmodule

bind hall_sector_angle_decoder_core hsad_checker u_hsad_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .sector_o            (sector_o),
  .sector_changed_o    (sector_changed_o),
  .direction_o         (direction_o),
  .electrical_angle_o  (electrical_angle_o),
  .zero_period_error_o (zero_period_error_o)
);
